[src/hrpr_pkg.sv]
// ----------------------------------------------------------------------------
// hrpr_pkg
// Types, codes and helpers shared by the hourly report push scheduler.
// ----------------------------------------------------------------------------
package hrpr_pkg;

    localparam int HOURS_PER_DAY = 24;
    localparam int HOUR_W        = 5;
    localparam int TICK_W        = 16;
    localparam int RETRY_W       = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [HOUR_W-1:0]  HOUR_LIMIT = HOUR_W'(HOURS_PER_DAY);
    localparam logic [TICK_W-1:0]  TICK_MAX   = {TICK_W{1'b1}};

    localparam logic [15:0] PERIOD_BASE_RST = 16'd48;
    localparam logic [3:0]  PERIOD_SPREAD_RST = 4'd0;
    localparam logic [7:0]  TIME_TIMEOUT_RST = 8'd4;
    localparam logic [7:0]  ACK_TIMEOUT_BASE_RST = 8'd8;
    localparam logic [1:0]  ACK_SPREAD_RST = 2'd0;
    localparam logic [2:0]  RETRY_LIMIT_RST = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_BASE      = 3'd0,
        CFG_PERIOD_SPREAD    = 3'd1,
        CFG_TIME_TIMEOUT     = 3'd2,
        CFG_ACK_TIMEOUT_BASE = 3'd3,
        CFG_ACK_SPREAD       = 3'd4,
        CFG_RETRY_LIMIT      = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_TIME_REQ = 2'd1,
        ACT_HOUR_REQ = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PHASE_CODE_IDLE      = 2'd0,
        PHASE_CODE_WAIT_TIME = 2'd1,
        PHASE_CODE_WAIT_ACK  = 2'd2
    } phase_code_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT_TIME = 3'b010,
        PH_WAIT_ACK  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] period_base;
        logic [3:0]  period_spread;
        logic [7:0]  time_timeout;
        logic [7:0]  ack_timeout_base;
        logic [1:0]  ack_spread;
        logic [2:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic              ack_seen;
        logic              hour_valid;
        logic [HOUR_W-1:0] reply_hour;
    } item_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [HOUR_W-1:0] req_hour;
        logic              clear_ack;
        logic              clear_hour;
        logic [1:0]        phase_out;
    } result_t;

    typedef struct packed {
        phase_t                   phase;
        logic [TICK_W-1:0]        tick_count;
        logic [RETRY_W-1:0]       retry_count;
        logic [HOUR_W-1:0]        current_hour;
        logic                     current_hour_valid;
        logic [HOUR_W-1:0]        sending_hour;
        logic                     sending_valid;
        logic [HOURS_PER_DAY-1:0] hour_acked;
    } state_t;

    function automatic logic [HOURS_PER_DAY-1:0] below_mask(input logic [HOUR_W-1:0] lim);
        logic [HOURS_PER_DAY-1:0] m;
        for (int i = 0; i < HOURS_PER_DAY; i++)
        begin
            m[i] = (int'(lim) > i);
        end
        return m;
    endfunction

    function automatic logic [HOUR_W-1:0] lowest_set(input logic [HOURS_PER_DAY-1:0] v);
        logic [HOUR_W-1:0] idx;
        idx = '0;
        for (int i = HOURS_PER_DAY - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = HOUR_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [TICK_W-1:0] tick_sat(input logic [TICK_W-1:0] t);
        return (t == TICK_MAX) ? t : t + TICK_W'(1);
    endfunction

endpackage

[src/hrpr_cfg.sv]
// ----------------------------------------------------------------------------
// hrpr_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hrpr_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [hrpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hrpr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output hrpr_pkg::cfg_t                     cfg
);

    hrpr_pkg::cfg_t cfg_reg;
    hrpr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (hrpr_pkg::cfg_index_t'(cfg_index))
                hrpr_pkg::CFG_PERIOD_BASE:      cfg_next.period_base      = cfg_data;
                hrpr_pkg::CFG_PERIOD_SPREAD:    cfg_next.period_spread    = cfg_data[3:0];
                hrpr_pkg::CFG_TIME_TIMEOUT:     cfg_next.time_timeout     = cfg_data[7:0];
                hrpr_pkg::CFG_ACK_TIMEOUT_BASE: cfg_next.ack_timeout_base = cfg_data[7:0];
                hrpr_pkg::CFG_ACK_SPREAD:       cfg_next.ack_spread       = cfg_data[1:0];
                hrpr_pkg::CFG_RETRY_LIMIT:      cfg_next.retry_limit      = cfg_data[2:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_base      <= hrpr_pkg::PERIOD_BASE_RST;
            cfg_reg.period_spread    <= hrpr_pkg::PERIOD_SPREAD_RST;
            cfg_reg.time_timeout     <= hrpr_pkg::TIME_TIMEOUT_RST;
            cfg_reg.ack_timeout_base <= hrpr_pkg::ACK_TIMEOUT_BASE_RST;
            cfg_reg.ack_spread       <= hrpr_pkg::ACK_SPREAD_RST;
            cfg_reg.retry_limit      <= hrpr_pkg::RETRY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/hrpr_step.sv]
// ----------------------------------------------------------------------------
// hrpr_step
// Next-state and result logic for one tick of the report scheduler.
// ----------------------------------------------------------------------------
module hrpr_step
(
    input  hrpr_pkg::state_t  state,
    input  hrpr_pkg::item_t   item,
    input  hrpr_pkg::cfg_t    cfg,
    output hrpr_pkg::state_t  state_next,
    output hrpr_pkg::result_t result
);

    logic [hrpr_pkg::TICK_W-1:0]        tick_inc;
    logic [hrpr_pkg::RETRY_W-1:0]       retry_inc;
    logic [hrpr_pkg::HOURS_PER_DAY-1:0] acked_set;
    logic [hrpr_pkg::HOURS_PER_DAY-1:0] pending;
    logic [hrpr_pkg::HOUR_W-1:0]        lim;
    logic [hrpr_pkg::HOUR_W-1:0]        backfill_hour;
    logic [16:0]                        period_lim;
    logic [8:0]                         ack_lim;
    logic                               reply_ok;
    logic [1:0]                         action;
    logic                               clr_ack;
    logic                               clr_hour;

    always_comb
    begin
        tick_inc  = hrpr_pkg::tick_sat(state.tick_count);
        retry_inc = state.retry_count + hrpr_pkg::RETRY_W'(1);
        acked_set = state.hour_acked;
        acked_set[state.sending_hour] = 1'b1;
        lim       = state.current_hour_valid ? state.current_hour : '0;
        pending   = ~acked_set & hrpr_pkg::below_mask(lim);
        backfill_hour = hrpr_pkg::lowest_set(pending);
        period_lim = 17'(cfg.period_base) + 17'(cfg.period_spread);
        ack_lim    = 9'(cfg.ack_timeout_base) + 9'(cfg.ack_spread);
        reply_ok   = item.hour_valid && (item.reply_hour < hrpr_pkg::HOUR_LIMIT);

        state_next = state;
        action     = hrpr_pkg::ACT_NONE;
        clr_ack    = 1'b0;
        clr_hour   = 1'b0;

        if (item.ack_seen && state.sending_valid)
        begin
            state_next.phase       = hrpr_pkg::PH_IDLE;
            state_next.tick_count  = '0;
            state_next.retry_count = '0;
            clr_ack  = 1'b1;
            clr_hour = 1'b1;
            if (state.current_hour_valid && state.current_hour == '0)
            begin
                state_next.hour_acked = hrpr_pkg::HOURS_PER_DAY'(1);
            end
            else
            begin
                state_next.hour_acked = acked_set;
                if (|pending)
                begin
                    state_next.phase        = hrpr_pkg::PH_WAIT_ACK;
                    state_next.sending_hour = backfill_hour;
                    action = hrpr_pkg::ACT_HOUR_REQ;
                end
            end
        end
        else
        begin
            unique case (state.phase)
                hrpr_pkg::PH_WAIT_TIME:
                begin
                    if (reply_ok)
                    begin
                        state_next.tick_count  = '0;
                        state_next.retry_count = '0;
                        if (state.current_hour_valid && item.reply_hour == state.current_hour)
                        begin
                            state_next.phase = hrpr_pkg::PH_IDLE;
                            clr_ack  = 1'b1;
                            clr_hour = 1'b1;
                        end
                        else
                        begin
                            state_next.current_hour       = item.reply_hour;
                            state_next.current_hour_valid = 1'b1;
                            state_next.phase              = hrpr_pkg::PH_WAIT_ACK;
                            state_next.sending_hour       = item.reply_hour;
                            state_next.sending_valid      = 1'b1;
                            clr_ack = 1'b1;
                            action  = hrpr_pkg::ACT_HOUR_REQ;
                            if (item.reply_hour == '0)
                            begin
                                state_next.hour_acked = '0;
                                clr_hour = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_next.tick_count = tick_inc;
                        if (tick_inc > hrpr_pkg::TICK_W'(cfg.time_timeout))
                        begin
                            state_next.tick_count = '0;
                            if (retry_inc < cfg.retry_limit)
                            begin
                                state_next.retry_count = retry_inc;
                                clr_hour = 1'b1;
                                action   = hrpr_pkg::ACT_TIME_REQ;
                            end
                            else
                            begin
                                state_next.retry_count = '0;
                                state_next.phase       = hrpr_pkg::PH_IDLE;
                                clr_ack  = 1'b1;
                                clr_hour = 1'b1;
                            end
                        end
                    end
                end
                hrpr_pkg::PH_WAIT_ACK:
                begin
                    state_next.tick_count = tick_inc;
                    if (tick_inc > hrpr_pkg::TICK_W'(ack_lim))
                    begin
                        state_next.tick_count = '0;
                        if (retry_inc < cfg.retry_limit)
                        begin
                            state_next.retry_count   = retry_inc;
                            state_next.sending_valid = 1'b1;
                            clr_ack = 1'b1;
                            action  = hrpr_pkg::ACT_HOUR_REQ;
                        end
                        else
                        begin
                            state_next.retry_count = '0;
                            state_next.phase       = hrpr_pkg::PH_IDLE;
                            clr_ack  = 1'b1;
                            clr_hour = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next.phase      = hrpr_pkg::PH_IDLE;
                    state_next.tick_count = tick_inc;
                    if (17'(tick_inc) > period_lim)
                    begin
                        state_next.tick_count  = '0;
                        state_next.retry_count = '0;
                        state_next.phase       = hrpr_pkg::PH_WAIT_TIME;
                        action = hrpr_pkg::ACT_TIME_REQ;
                    end
                end
            endcase
        end

        result.action     = action;
        result.req_hour   = (action == hrpr_pkg::ACT_HOUR_REQ) ? state_next.sending_hour : '0;
        result.clear_ack  = clr_ack;
        result.clear_hour = clr_hour;
        unique case (state_next.phase)
            hrpr_pkg::PH_WAIT_TIME: result.phase_out = hrpr_pkg::PHASE_CODE_WAIT_TIME;
            hrpr_pkg::PH_WAIT_ACK:  result.phase_out = hrpr_pkg::PHASE_CODE_WAIT_ACK;
            default:                result.phase_out = hrpr_pkg::PHASE_CODE_IDLE;
        endcase
    end

endmodule

[src/hourly_report_push_retry_fsm.sv]
// ----------------------------------------------------------------------------
// hourly_report_push_retry_fsm
// Hourly report push scheduler with retries, acknowledge bitmap and backfill.
// Each tick passes the input register, then the result register. Throughput:
// one tick per cycle while results are taken, set by the input to result step;
// a waiting result lets one more tick in, then holds the input.
// Reset: asynchronous, clears phase to idle, counters, valid flags and the
// acknowledge bitmap; configuration returns to its default values.
// ----------------------------------------------------------------------------
module hourly_report_push_retry_fsm
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               ack_seen,
    input  logic                               hour_valid,
    input  logic [hrpr_pkg::HOUR_W-1:0]        reply_hour,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         action,
    output logic [hrpr_pkg::HOUR_W-1:0]        req_hour,
    output logic                               clear_ack,
    output logic                               clear_hour,
    output logic [1:0]                         phase_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hrpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hrpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    hrpr_pkg::cfg_t    cfg;
    hrpr_pkg::item_t   item_reg;
    hrpr_pkg::item_t   item_next;
    logic              item_valid_reg;
    logic              item_valid_next;
    hrpr_pkg::state_t  state_reg;
    hrpr_pkg::state_t  state_next;
    hrpr_pkg::state_t  state_calc;
    hrpr_pkg::result_t result_calc;
    hrpr_pkg::result_t result_reg;
    hrpr_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              in_fire;

    assign cfg_ready = 1'b1;

    hrpr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hrpr_step u_step
    (
        .state      (state_reg),
        .item       (item_reg),
        .cfg        (cfg),
        .state_next (state_calc),
        .result     (result_calc)
    );

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        if (advance)
        begin
            item_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            item_next.ack_seen   = ack_seen;
            item_next.hour_valid = hour_valid;
            item_next.reply_hour = reply_hour;
            item_valid_next      = 1'b1;
        end

        state_next     = advance ? state_calc : state_reg;
        result_next    = advance ? result_calc : result_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg                 <= 1'b0;
            out_valid_reg                  <= 1'b0;
            state_reg.phase                <= hrpr_pkg::PH_IDLE;
            state_reg.tick_count           <= '0;
            state_reg.retry_count          <= '0;
            state_reg.current_hour         <= '0;
            state_reg.current_hour_valid   <= 1'b0;
            state_reg.sending_hour         <= '0;
            state_reg.sending_valid        <= 1'b0;
            state_reg.hour_acked           <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign action     = result_reg.action;
    assign req_hour   = result_reg.req_hour;
    assign clear_ack  = result_reg.clear_ack;
    assign clear_hour = result_reg.clear_hour;
    assign phase_out  = result_reg.phase_out;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Block-level testbench for the hourly report push scheduler. Ticks go in over
// a valid/ready channel with random bursts and gaps, and results come out
// under a receiver that stalls in shifting patterns. An in-bench model of the
// scheduler (phase, counters, hour tracking, acknowledge bitmap and backfill)
// predicts one report per tick. Each report is checked field by field in
// order. Configuration is rewritten between runs, only once nothing is pending.
// The runs cover defaults, directed corner cases, retry and timeout extremes,
// a long idle period, and phase-aware random traffic.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int TICK_CEIL    = 65535;

    typedef enum int {
        RX_OPEN,
        RX_SPARSE,
        RX_EVERY_THIRD,
        RX_HALF
    } rx_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            ack_seen;
    logic                            hour_valid;
    logic [hrpr_pkg::HOUR_W-1:0]     reply_hour;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      action;
    logic [hrpr_pkg::HOUR_W-1:0]     req_hour;
    logic                            clear_ack;
    logic                            clear_hour;
    logic [1:0]                      phase_out;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hrpr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hrpr_pkg::CFG_DATA_W-1:0] cfg_data;

    int period_base_r;
    int period_spread_r;
    int time_timeout_r;
    int ack_base_r;
    int ack_spread_r;
    int retry_limit_r;

    hrpr_pkg::phase_code_t              sched_phase;
    int                                 tick_count;
    int                                 retry_count;
    logic [hrpr_pkg::HOUR_W-1:0]        cur_hour;
    bit                                 cur_hour_valid;
    logic [hrpr_pkg::HOUR_W-1:0]        sent_hour;
    bit                                 sent_valid;
    bit [hrpr_pkg::HOURS_PER_DAY-1:0]   hours_acked;
    hrpr_pkg::result_t                  step_out;

    hrpr_pkg::result_t expected_reports[$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                stall_left = 0;
    rx_mode_t          stall_mode = RX_OPEN;

    hourly_report_push_retry_fsm DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ack_seen   (ack_seen),
        .hour_valid (hour_valid),
        .reply_hour (reply_hour),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .action     (action),
        .req_hour   (req_hour),
        .clear_ack  (clear_ack),
        .clear_hour (clear_hour),
        .phase_out  (phase_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("hourly_report_push_retry_fsm verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(4, 60);
            stall_mode = rx_mode_t'($urandom_range(0, 3));
        end
        stall_left--;
        case (stall_mode)
            RX_OPEN:        out_ready = 1'b1;
            RX_SPARSE:      out_ready = ($urandom_range(0, 3) != 0);
            RX_EVERY_THIRD: out_ready = ((stall_left % 3) != 0);
            default:        out_ready = ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_reports
        hrpr_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report with no pending tick: action %0d req_hour %0d", action, req_hour);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    mismatch_count++;
                end
                if (req_hour !== want.req_hour)
                begin
                    $error("req_hour: expected %0d, got %0d", want.req_hour, req_hour);
                    mismatch_count++;
                end
                if (clear_ack !== want.clear_ack)
                begin
                    $error("clear_ack: expected %0d, got %0d", want.clear_ack, clear_ack);
                    mismatch_count++;
                end
                if (clear_hour !== want.clear_hour)
                begin
                    $error("clear_hour: expected %0d, got %0d", want.clear_hour, clear_hour);
                    mismatch_count++;
                end
                if (phase_out !== want.phase_out)
                begin
                    $error("phase_out: expected %0d, got %0d", want.phase_out, phase_out);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void reset_schedule();
        period_base_r   = int'(hrpr_pkg::PERIOD_BASE_RST);
        period_spread_r = int'(hrpr_pkg::PERIOD_SPREAD_RST);
        time_timeout_r  = int'(hrpr_pkg::TIME_TIMEOUT_RST);
        ack_base_r      = int'(hrpr_pkg::ACK_TIMEOUT_BASE_RST);
        ack_spread_r    = int'(hrpr_pkg::ACK_SPREAD_RST);
        retry_limit_r   = int'(hrpr_pkg::RETRY_LIMIT_RST);
        sched_phase     = hrpr_pkg::PHASE_CODE_IDLE;
        tick_count      = 0;
        retry_count     = 0;
        cur_hour        = '0;
        cur_hour_valid  = 1'b0;
        sent_hour       = '0;
        sent_valid      = 1'b0;
        hours_acked     = '0;
    endfunction

    function automatic void return_idle(input bit new_day);
        retry_count         = 0;
        tick_count          = 0;
        step_out.clear_ack  = 1'b1;
        step_out.clear_hour = 1'b1;
        sched_phase         = hrpr_pkg::PHASE_CODE_IDLE;
        if (new_day)
        begin
            hours_acked = '0;
        end
    endfunction

    function automatic void push_report(input logic [hrpr_pkg::HOUR_W-1:0] hour);
        sent_hour          = hour;
        sent_valid         = 1'b1;
        step_out.clear_ack = 1'b1;
        step_out.action    = hrpr_pkg::ACT_HOUR_REQ;
    endfunction

    function automatic void count_tick();
        if (tick_count < TICK_CEIL)
        begin
            tick_count++;
        end
    endfunction

    function automatic hrpr_pkg::result_t schedule_step(input hrpr_pkg::item_t it);
        int lim;
        bit found;
        step_out = '0;
        if (it.ack_seen && sent_valid)
        begin
            if (sent_hour < hrpr_pkg::HOURS_PER_DAY)
            begin
                hours_acked[sent_hour] = 1'b1;
            end
            if (cur_hour_valid && cur_hour == '0)
            begin
                return_idle(1'b1);
                hours_acked[0] = 1'b1;
            end
            else
            begin
                lim = cur_hour_valid ? int'(cur_hour) : 0;
                return_idle(1'b0);
                if (lim > hrpr_pkg::HOURS_PER_DAY)
                begin
                    lim = hrpr_pkg::HOURS_PER_DAY;
                end
                found = 1'b0;
                for (int i = 0; i < lim; i++)
                begin
                    if (!found && !hours_acked[i])
                    begin
                        found       = 1'b1;
                        sched_phase = hrpr_pkg::PHASE_CODE_WAIT_ACK;
                        push_report(hrpr_pkg::HOUR_W'(i));
                    end
                end
            end
        end
        else if (sched_phase == hrpr_pkg::PHASE_CODE_WAIT_TIME)
        begin
            if (it.hour_valid && it.reply_hour < hrpr_pkg::HOURS_PER_DAY)
            begin
                if (cur_hour_valid && it.reply_hour == cur_hour)
                begin
                    return_idle(1'b0);
                end
                else
                begin
                    cur_hour       = it.reply_hour;
                    cur_hour_valid = 1'b1;
                    if (it.reply_hour == '0)
                    begin
                        return_idle(1'b1);
                    end
                    retry_count = 0;
                    tick_count  = 0;
                    sched_phase = hrpr_pkg::PHASE_CODE_WAIT_ACK;
                    push_report(it.reply_hour);
                end
            end
            else
            begin
                count_tick();
                if (tick_count > time_timeout_r)
                begin
                    retry_count = (retry_count + 1) % 8;
                    if (retry_count < retry_limit_r)
                    begin
                        tick_count          = 0;
                        step_out.clear_hour = 1'b1;
                        step_out.action     = hrpr_pkg::ACT_TIME_REQ;
                    end
                    else
                    begin
                        return_idle(1'b0);
                    end
                end
            end
        end
        else if (sched_phase == hrpr_pkg::PHASE_CODE_WAIT_ACK)
        begin
            count_tick();
            if (tick_count > ack_base_r + ack_spread_r)
            begin
                retry_count = (retry_count + 1) % 8;
                if (retry_count < retry_limit_r)
                begin
                    tick_count = 0;
                    push_report(sent_hour);
                end
                else
                begin
                    return_idle(1'b0);
                end
            end
        end
        else
        begin
            count_tick();
            if (tick_count > period_base_r + period_spread_r)
            begin
                retry_count     = 0;
                tick_count      = 0;
                sched_phase     = hrpr_pkg::PHASE_CODE_WAIT_TIME;
                step_out.action = hrpr_pkg::ACT_TIME_REQ;
            end
        end
        if (step_out.action == hrpr_pkg::ACT_HOUR_REQ)
        begin
            step_out.req_hour = sent_hour;
        end
        step_out.phase_out = sched_phase;
        return step_out;
    endfunction

    task automatic send_tick(input logic ack, input logic hv,
                             input logic [hrpr_pkg::HOUR_W-1:0] hour);
        int              gap;
        hrpr_pkg::item_t it;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        it.ack_seen   = ack;
        it.hour_valid = hv;
        it.reply_hour = hour;
        in_valid      = 1'b1;
        ack_seen      = ack;
        hour_valid    = hv;
        reply_hour    = hour;
        do @(posedge clk); while (!in_ready);
        expected_reports.push_back(schedule_step(it));
        burst_left--;
    endtask

    task automatic send_random_tick();
        logic                        ack;
        logic                        hv;
        logic [hrpr_pkg::HOUR_W-1:0] hour;
        int                          roll;
        roll = $urandom_range(0, 99);
        ack  = 1'b0;
        hv   = 1'b0;
        hour = hrpr_pkg::HOUR_W'($urandom_range(0, 31));
        case (sched_phase)
            hrpr_pkg::PHASE_CODE_WAIT_TIME:
            begin
                ack = ($urandom_range(0, 9) == 0);
                hv  = (roll < 88);
                if (roll < 55)
                begin
                    hour = hrpr_pkg::HOUR_W'((int'(cur_hour) + $urandom_range(1, 3))
                                             % hrpr_pkg::HOURS_PER_DAY);
                end
                else if (roll < 70)
                begin
                    hour = hrpr_pkg::HOUR_W'($urandom_range(0, hrpr_pkg::HOURS_PER_DAY - 1));
                end
                else if (roll < 80)
                begin
                    hour = cur_hour;
                end
                else if (roll < 88)
                begin
                    hour = hrpr_pkg::HOUR_W'($urandom_range(hrpr_pkg::HOURS_PER_DAY, 31));
                end
            end
            hrpr_pkg::PHASE_CODE_WAIT_ACK:
            begin
                ack = (roll < 35);
                hv  = ($urandom_range(0, 4) == 0);
            end
            default:
            begin
                ack = (roll < 10);
                hv  = ($urandom_range(0, 4) == 0);
            end
        endcase
        send_tick(ack, hv, hour);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_tick();
    endtask

    task automatic run_to_time_request();
        while (sched_phase != hrpr_pkg::PHASE_CODE_WAIT_TIME)
        begin
            send_tick(1'b0, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input hrpr_pkg::cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = hrpr_pkg::CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            hrpr_pkg::CFG_PERIOD_BASE:      period_base_r   = value & 16'hFFFF;
            hrpr_pkg::CFG_PERIOD_SPREAD:    period_spread_r = value & 4'hF;
            hrpr_pkg::CFG_TIME_TIMEOUT:     time_timeout_r  = value & 8'hFF;
            hrpr_pkg::CFG_ACK_TIMEOUT_BASE: ack_base_r      = value & 8'hFF;
            hrpr_pkg::CFG_ACK_SPREAD:       ack_spread_r    = value & 2'h3;
            hrpr_pkg::CFG_RETRY_LIMIT:      retry_limit_r   = value & 3'h7;
            default:                        ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_config(input int pb, input int ps, input int tt,
                               input int ab, input int sp, input int rl);
        wait_drained();
        write_reg(hrpr_pkg::CFG_PERIOD_BASE, pb);
        write_reg(hrpr_pkg::CFG_PERIOD_SPREAD, ps);
        write_reg(hrpr_pkg::CFG_TIME_TIMEOUT, tt);
        write_reg(hrpr_pkg::CFG_ACK_TIMEOUT_BASE, ab);
        write_reg(hrpr_pkg::CFG_ACK_SPREAD, sp);
        write_reg(hrpr_pkg::CFG_RETRY_LIMIT, rl);
    endtask

    task automatic test_reset_defaults();
        // ack with no hour sent yet must be ignored
        repeat (5) send_tick(1'b1, 1'b1, hrpr_pkg::HOUR_W'($urandom_range(0, 31)));
        run_random(25);
    endtask

    task automatic test_directed();
        load_config(1, 0, 1, 1, 0, 2);
        run_to_time_request();
        send_tick(1'b0, 1'b1, 5'd31);
        send_tick(1'b0, 1'b1, 5'd24);
        send_tick(1'b0, 1'b1, 5'd23);
        send_tick(1'b0, 1'b0, 5'd0);
        send_tick(1'b0, 1'b0, 5'd0);
        send_tick(1'b1, 1'b0, 5'd0);
        send_tick(1'b1, 1'b0, 5'd0);
        repeat (4) send_tick(1'b0, 1'b0, 5'd0);
        send_tick(1'b1, 1'b0, 5'd0);
        run_to_time_request();
        send_tick(1'b1, 1'b1, 5'd5);
        run_to_time_request();
        send_tick(1'b0, 1'b1, 5'd0);
        send_tick(1'b1, 1'b0, 5'd0);
        run_to_time_request();
        send_tick(1'b0, 1'b1, 5'd0);
        run_to_time_request();
        send_tick(1'b0, 1'b1, 5'd7);
        repeat (4) send_tick(1'b1, 1'b0, 5'd0);
    endtask

    task automatic test_retry_extremes();
        load_config(1, 0, 1, 1, 0, 0);
        run_random(20);
        load_config(2, 1, 2, 1, 1, 7);
        run_random(30);
    endtask

    task automatic test_timeout_extremes();
        load_config(1, 15, 255, 255, 3, 2);
        run_to_time_request();
        repeat (260)
        begin
            send_tick(1'b0, 1'($urandom_range(0, 1)),
                      hrpr_pkg::HOUR_W'($urandom_range(hrpr_pkg::HOURS_PER_DAY, 31)));
        end
        send_tick(1'b0, 1'b1,
                  hrpr_pkg::HOUR_W'((int'(cur_hour) + 1) % hrpr_pkg::HOURS_PER_DAY));
        repeat (262) send_tick(1'b0, 1'b0, 5'd0);
        send_tick(1'b1, 1'b0, 5'd0);
    endtask

    task automatic test_long_idle();
        // hold idle under a period past the tick counter's ceiling; no time request comes
        load_config(65535, 14, 1, 1, 0, 1);
        repeat (40)
        begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), hrpr_pkg::HOUR_W'($urandom_range(0, 31)));
        end
        load_config(3, 0, 2, 2, 0, 3);
        run_random(15);
    endtask

    task automatic test_random_traffic();
        repeat (4)
        begin
            load_config(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6),
                        $urandom_range(0, 15), $urandom_range(1, 6), $urandom_range(1, 8),
                        $urandom_range(0, 3), $urandom_range(0, 7));
            run_random(20);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        ack_seen   = 1'b0;
        hour_valid = 1'b0;
        reply_hour = '0;
        cfg_valid  = 1'b0;
        cfg_index  = hrpr_pkg::CFG_PERIOD_BASE;
        cfg_data   = '0;
        reset_schedule();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed();
        test_retry_extremes();
        test_timeout_extremes();
        test_long_idle();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
        begin
            $display("hourly_report_push_retry_fsm verification clean");
        end
        else
        begin
            $display("hourly_report_push_retry_fsm verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/hrpr_pkg.sv
src/hrpr_cfg.sv
src/hrpr_step.sv
src/hourly_report_push_retry_fsm.sv
tb/testbench.sv
